/* src/ccx_pkg.sv */
// Package: ChaCha20 stream XOR types, constants and helper functions.
`default_nettype none
package ccx_pkg;
  localparam int ROUNDS = 20;
  localparam int DR_CNT = (ROUNDS + 1) / 2;
  localparam int DRW = $clog2(DR_CNT + 1);
  localparam int QDEPTH = 2;

  localparam logic [2:0] REG_KEY_LOW      = 3'd0;
  localparam logic [2:0] REG_KEY_MID_LOW  = 3'd1;
  localparam logic [2:0] REG_KEY_MID_HIGH = 3'd2;
  localparam logic [2:0] REG_KEY_HIGH     = 3'd3;
  localparam logic [2:0] REG_NONCE        = 3'd4;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;

  // classified chunk passed from front to back
  typedef struct packed {
    logic [63:0] msg;
    logic [3:0]  cnt;
    logic        ends;
    logic        new_blk;
    logic [2:0]  pos;
    logic [63:0] ctr;
  } job_t;

  function automatic word_t rotl(input word_t v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [127:0] qr(input word_t a, input word_t b,
                                      input word_t c, input word_t d);
    word_t a1, b1, c1, d1;
    a1 = a + b;  d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qr = {a1, b1, c1, d1};
  endfunction

  function automatic blk_t col_round(input blk_t x);
    blk_t y;
    logic [127:0] t;
    y = x;
    for (int i = 0; i < 4; i++) begin
      t = qr(x[i], x[i+4], x[i+8], x[i+12]);
      {y[i], y[i+4], y[i+8], y[i+12]} = t;
    end
    col_round = y;
  endfunction

  function automatic blk_t diag_round(input blk_t x);
    blk_t y;
    logic [127:0] t;
    y = x;
    for (int i = 0; i < 4; i++) begin
      t = qr(x[i], x[4 + ((i+1) % 4)], x[8 + ((i+2) % 4)], x[12 + ((i+3) % 4)]);
      {y[i], y[4 + ((i+1) % 4)], y[8 + ((i+2) % 4)], y[12 + ((i+3) % 4)]} = t;
    end
    diag_round = y;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) m[8*i +: 8] = (cnt > 4'(i)) ? 8'hff : 8'h00;
    byte_mask = m;
  endfunction
endpackage
`default_nettype wire

/* src/ccx_if.sv */
// Interfaces: valid/ready data channels for chunks, results and config.
`default_nettype none
interface ccx_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_chunk;
  logic [3:0]  byte_count;
  logic        starts_message;
  logic        ends_message;
  modport source(output valid, msg_chunk, byte_count, starts_message, ends_message,
                 input ready);
  modport sink(input valid, msg_chunk, byte_count, starts_message, ends_message,
               output ready);
endinterface

interface ccx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_chunk;
  logic [3:0]  valid_bytes;
  logic        message_end;
  modport source(output valid, cipher_chunk, valid_bytes, message_end, input ready);
  modport sink(input valid, cipher_chunk, valid_bytes, message_end, output ready);
endinterface

interface ccx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/chacha20_stream_xor.sv */
// Top level: ChaCha20 stream XOR with config registers, front, queue, back.
`default_nettype none
// A chunk that opens a 64-byte block waits while its keystream is computed (10
// double rounds in one shared round unit), then goes through the XOR register;
// other chunks need only the XOR register. The single double-round unit limits
// throughput: no chunk is taken while it computes a block.
// Reset: rst_n synchronous active low clears counter, position, queue, FSM
// and key/nonce registers; the keystream block is undefined until computed.
module chacha20_stream_xor (
  input  wire logic clk,
  input  wire logic rst_n,
  ccx_in_if.sink    in_ch,
  ccx_out_if.source out_ch,
  ccx_cfg_if.sink   cfg_ch
);
  import ccx_pkg::*;

  logic [63:0] key_r [4];
  logic [63:0] nonce_r;
  job_t f_job, q_job, b_job;
  logic f_valid, f_ready, q_valid, q_ready;
  logic busy;
  logic done_r;   // block for head job already computed

  // config transaction: always accepted
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY_LOW:      key_r[0] <= cfg_ch.data;
        REG_KEY_MID_LOW:  key_r[1] <= cfg_ch.data;
        REG_KEY_MID_HIGH: key_r[2] <= cfg_ch.data;
        REG_KEY_HIGH:     key_r[3] <= cfg_ch.data;
        REG_NONCE:        nonce_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  ccx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  ccx_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // head job that opens a block is shown to the back as a block request
  // until its keystream is ready, then as a plain chunk
  always_comb begin
    b_job = q_job;
    if (done_r) b_job.new_blk = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else if (q_valid && q_ready) done_r <= 1'b0;
    else if (busy) done_r <= 1'b1;
  end

  ccx_back u_back (
    .clk(clk), .rst_n(rst_n),
    .key({key_r[3], key_r[2], key_r[1], key_r[0]}), .nonce(nonce_r),
    .job(b_job), .job_valid(q_valid && !busy), .job_ready(q_ready),
    .out_ch(out_ch), .busy(busy)
  );

`ifndef ASSERT_OFF
  // no chunk leaves the queue while the round unit works
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_ready) else $error("chunk taken during block compute");
  // a result waiting unaccepted keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.cipher_chunk))
    else $error("result changed while stalled");
  // a block-opening chunk is only taken after its keystream is computed
  a_blk_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready && q_job.new_blk |-> done_r) else $error("keystream not ready");
`endif
endmodule
`default_nettype wire

/* src/ccx_front.sv */
// Front end: tracks counter/position and classifies each chunk.
`default_nettype none
module ccx_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ccx_in_if.sink             in_ch,
  output ccx_pkg::job_t      job,
  output logic               job_valid,
  input  wire logic          job_ready
);
  import ccx_pkg::*;
  logic [63:0] ctr_r, ctr_nxt, cur_ctr;
  logic [2:0]  pos_r, pos_nxt, cur_pos;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign cur_pos = in_ch.starts_message ? 3'd0 : pos_r;
  assign cur_ctr = in_ch.starts_message ? 64'd0 : ctr_r;

  always_comb begin
    job.msg     = in_ch.msg_chunk;
    job.cnt     = in_ch.byte_count;
    job.ends    = in_ch.ends_message;
    job.new_blk = (cur_pos == 3'd0);
    job.pos     = cur_pos;
    job.ctr     = cur_ctr;
    pos_nxt = pos_r;
    ctr_nxt = ctr_r;
    if (in_ch.valid && job_ready) begin
      pos_nxt = cur_pos + 3'd1;
      ctr_nxt = (cur_pos == 3'd0) ? cur_ctr + 64'd1 : cur_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ctr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ctr_r <= ctr_nxt;
    end
  end
endmodule
`default_nettype wire

/* src/ccx_queue.sv */
// Small FIFO of classified chunks between front and back.
`default_nettype none
module ccx_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ccx_pkg::job_t      wr_job,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output ccx_pkg::job_t      rd_job,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  import ccx_pkg::*;
  localparam int AW = $clog2(QDEPTH);
  job_t mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule
`default_nettype wire

/* src/ccx_back.sv */
// Back end: double-round core, keystream block and XOR output register.
`default_nettype none
module ccx_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [255:0]  key,
  input  wire logic [63:0]   nonce,
  input  ccx_pkg::job_t      job,
  input  wire logic          job_valid,
  output logic               job_ready,
  ccx_out_if.source          out_ch,
  output logic               busy
);
  import ccx_pkg::*;
  typedef enum logic [1:0] {S_IDLE = 2'b01, S_RUN = 2'b10} st_t;
  st_t st_r, st_nxt;
  blk_t init_r, w_r, ks_r, init_c, dr;
  logic [DRW-1:0] dr_r;
  logic ov_r;
  logic [63:0] ks64;
  logic take;

  always_comb begin
    init_c[0] = 32'h61707865; init_c[1] = 32'h3320646e;
    init_c[2] = 32'h79622d32; init_c[3] = 32'h6b206574;
    for (int i = 0; i < 8; i++) init_c[4+i] = key[32*i +: 32];
    init_c[12] = job.ctr[31:0];  init_c[13] = job.ctr[63:32];
    init_c[14] = nonce[31:0];    init_c[15] = nonce[63:32];
    // odd round counts end on a lone column round
    if ((ROUNDS % 2 == 1) && dr_r == DRW'(DR_CNT - 1)) dr = col_round(w_r);
    else dr = diag_round(col_round(w_r));
  end

  // output slot frees when empty or being taken this cycle
  assign take = (st_r == S_IDLE) && job_valid && !job.new_blk
                && (!ov_r || out_ch.ready);
  assign job_ready = take;
  assign ks64 = {ks_r[{job.pos, 1'b1}], ks_r[{job.pos, 1'b0}]};
  assign busy = (st_r == S_RUN);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (job_valid && job.new_blk) st_nxt = S_RUN;
      S_RUN:  if (dr_r == DRW'(DR_CNT - 1)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && job_valid && job.new_blk) begin
      init_r <= init_c;
      w_r    <= init_c;
    end else if (st_r == S_RUN) begin
      w_r <= dr;
      if (dr_r == DRW'(DR_CNT - 1))
        for (int i = 0; i < 16; i++) ks_r[i] <= dr[i] + init_r[i];
    end
    if (take) begin
      out_ch.cipher_chunk <= (job.msg ^ ks64) & byte_mask(job.cnt);
      out_ch.valid_bytes  <= job.cnt;
      out_ch.message_end  <= job.ends;
    end
  end

  // once a block completes, the top level shows the head job with new_blk
  // cleared, so it is then taken as a plain chunk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; dr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_RUN) dr_r <= dr_r + 1'b1;
      else dr_r <= '0;
      if (take) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end
  assign out_ch.valid = ov_r;
endmodule
`default_nettype wire
